// ----- rtl/ssr_pkg.sv -----
`default_nettype none
package ssr_pkg;

	// sizes
	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 4096;
	localparam int MAX_STEPS    = 8;
	localparam int FRAC_BITS    = 30;

	localparam int VTX_W    = 10;
	localparam int VCNT_W   = 11;
	localparam int OFF_W    = 13;
	localparam int OFF_AW   = 11;
	localparam int EDGE_AW  = 12;
	localparam int NBR_W    = 10;
	localparam int SCORE_W  = 32;
	localparam int LVL_W    = 4;
	localparam int WALK_AW  = 14;
	localparam int BACK_AW  = 11;

	localparam int OFF_DEPTH  = MAX_VERTICES + 1;
	localparam int WALK_DEPTH = (MAX_STEPS + 1) * MAX_VERTICES;
	localparam int BACK_DEPTH = 2 * MAX_VERTICES;

	localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(64'd1 << FRAC_BITS);

	// transaction kinds
	localparam logic [2:0] KIND_OUT_OFF = 3'd0;
	localparam logic [2:0] KIND_OUT_NBR = 3'd1;
	localparam logic [2:0] KIND_IN_OFF  = 3'd2;
	localparam logic [2:0] KIND_IN_NBR  = 3'd3;
	localparam logic [2:0] KIND_RUN     = 3'd4;
	localparam logic [2:0] KIND_READ    = 3'd5;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// register map
	localparam logic [1:0] REG_METHOD = 2'd0;
	localparam logic [1:0] REG_DECAY  = 2'd1;
	localparam logic [1:0] REG_STEPS  = 2'd2;
	localparam logic [1:0] REG_VCOUNT = 2'd3;

	localparam logic [15:0]       DECAY_RST  = 16'd39322;
	localparam logic [LVL_W-1:0]  STEPS_RST  = 4'd5;
	localparam logic [VCNT_W-1:0] VCOUNT_RST = 11'd1024;

	// graph store requests
	typedef struct packed {
		logic               oo_we;
		logic               io_we;
		logic               on_we;
		logic               in_we;
		logic [OFF_W-1:0]   load_addr;
		logic [OFF_W-1:0]   load_data;
		logic [OFF_AW-1:0]  oo_raddr;
		logic [OFF_AW-1:0]  io_raddr;
		logic [EDGE_AW-1:0] on_raddr;
		logic [EDGE_AW-1:0] in_raddr;
	} gr_req_t;

	typedef struct packed {
		logic [OFF_W-1:0] oo_rdata;
		logic [OFF_W-1:0] io_rdata;
		logic [NBR_W-1:0] on_rdata;
		logic [NBR_W-1:0] in_rdata;
	} gr_rsp_t;

	// vector store requests
	typedef struct packed {
		logic               walk_we;
		logic [WALK_AW-1:0] walk_waddr;
		logic [SCORE_W-1:0] walk_wdata;
		logic [WALK_AW-1:0] walk_raddr;
		logic               back_we;
		logic [BACK_AW-1:0] back_waddr;
		logic [SCORE_W-1:0] back_wdata;
		logic [BACK_AW-1:0] back_raddr;
	} vec_req_t;

	// saturating add of a partial sum
	function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
			input logic [SCORE_W-1:0] b);
		logic [SCORE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[SCORE_W] ? '1 : s[SCORE_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/ssr_div.sv -----
`default_nettype none
// restoring divider, four quotient bits per cycle
module ssr_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ssr_pkg::SCORE_W-1:0]   num,
	input  wire logic [ssr_pkg::OFF_W-1:0]     den,
	output logic                               busy,
	output logic                               done,
	output logic [ssr_pkg::SCORE_W-1:0]        quot,
	output logic [ssr_pkg::OFF_W-1:0]          rem
);

	logic [ssr_pkg::SCORE_W-1:0] num_q;
	logic [ssr_pkg::OFF_W-1:0]   rem_q;
	logic [ssr_pkg::OFF_W-1:0]   den_q;
	logic [2:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ssr_pkg::SCORE_W-1:0] num_nx;
	logic [ssr_pkg::OFF_W-1:0]   rem_nx;

	// four restoring steps
	always_comb begin
		logic [ssr_pkg::OFF_W:0] rs;
		num_nx = num_q;
		rem_nx = rem_q;
		for (int j = 0; j < 4; j++) begin
			rs = {rem_nx, num_nx[ssr_pkg::SCORE_W-1]};
			num_nx = {num_nx[ssr_pkg::SCORE_W-2:0], 1'b0};
			if (rs >= {1'b0, den_q}) begin
				rs = rs - {1'b0, den_q};
				num_nx[0] = 1'b1;
			end
			rem_nx = rs[ssr_pkg::OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/ssr_graph_store.sv -----
`default_nettype none
// out/in offset and neighbor memories, one write and one read each per cycle
module ssr_graph_store (
	input  wire logic             clk,
	input  wire ssr_pkg::gr_req_t req,
	output ssr_pkg::gr_rsp_t      rsp
);

	logic [ssr_pkg::OFF_W-1:0] oo_mem [ssr_pkg::OFF_DEPTH];
	logic [ssr_pkg::OFF_W-1:0] io_mem [ssr_pkg::OFF_DEPTH];
	logic [ssr_pkg::NBR_W-1:0] on_mem [ssr_pkg::MAX_EDGES];
	logic [ssr_pkg::NBR_W-1:0] in_mem [ssr_pkg::MAX_EDGES];

	// loads
	always_ff @(posedge clk) begin
		if (req.oo_we)
			oo_mem[req.load_addr[ssr_pkg::OFF_AW-1:0]] <= req.load_data;
		if (req.io_we)
			io_mem[req.load_addr[ssr_pkg::OFF_AW-1:0]] <= req.load_data;
		if (req.on_we)
			on_mem[req.load_addr[ssr_pkg::EDGE_AW-1:0]] <= req.load_data[ssr_pkg::NBR_W-1:0];
		if (req.in_we)
			in_mem[req.load_addr[ssr_pkg::EDGE_AW-1:0]] <= req.load_data[ssr_pkg::NBR_W-1:0];
	end

	// registered reads
	always_ff @(posedge clk) begin
		rsp.oo_rdata <= oo_mem[req.oo_raddr];
		rsp.io_rdata <= io_mem[req.io_raddr];
		rsp.on_rdata <= on_mem[req.on_raddr];
		rsp.in_rdata <= in_mem[req.in_raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/ssr_vec_store.sv -----
`default_nettype none
// walk vectors and the two back-vector banks; back banks zeroed after reset
module ssr_vec_store (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ssr_pkg::vec_req_t           req,
	output logic [ssr_pkg::SCORE_W-1:0]      walk_rdata,
	output logic [ssr_pkg::SCORE_W-1:0]      back_rdata,
	output logic                             clr_busy
);

	logic [ssr_pkg::SCORE_W-1:0] walk_mem [ssr_pkg::WALK_DEPTH];
	logic [ssr_pkg::SCORE_W-1:0] back_mem [ssr_pkg::BACK_DEPTH];
	logic [ssr_pkg::BACK_AW:0]   clr_cnt_q;

	assign clr_busy = ~clr_cnt_q[ssr_pkg::BACK_AW];

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (clr_busy)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (req.walk_we)
			walk_mem[req.walk_waddr] <= req.walk_wdata;
		walk_rdata <= walk_mem[req.walk_raddr];
	end

	always_ff @(posedge clk) begin
		if (clr_busy)
			back_mem[clr_cnt_q[ssr_pkg::BACK_AW-1:0]] <= '0;
		else if (req.back_we)
			back_mem[req.back_waddr] <= req.back_wdata;
		back_rdata <= back_mem[req.back_raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/single_source_simrank_engine.sv -----
// Single-source SimRank engine.
// Input channel (item_valid/item_ready): kind, index, value. Loads of the
// out/in offset and neighbor lists give no result unless the index is out
// of range (status 2). A read returns one score. A run takes a query
// vertex, builds the walk vectors over step_count steps, then the backward
// pass, and returns vertex q, status 1.
// Result channel (res_valid/res_ready): vertex, score, status, held in an
// output register; a stalled receiver holds it, and the next transaction is
// still taken but its result waits in the emit state until the register frees.
// One transaction is worked on at a time. Pruned runs add a scaling pass.
// Configuration: APB, registers at byte addresses 0,4,8,12, pready always
// high. After reset the back-vector banks are zeroed by a clearing pass,
// during which no transaction is accepted.
`default_nettype none
module single_source_simrank_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [12:0] index,
	input  wire logic [12:0] value,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [9:0]       vertex,
	output logic [31:0]      score,
	output logic [1:0]       status
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_RD_WAIT, S_EMIT, S_INIT,
		S_F_OFF0, S_F_OFF1, S_F_OFF2, S_F_E0, S_F_E1, S_F_E2, S_F_E3, S_F_DIV,
		S_B_V0, S_B_V1, S_B_V2, S_B_DG, S_B_O0, S_B_O1, S_B_O2,
		S_B_E0, S_B_E1, S_B_E2, S_B_E3, S_B_DIV, S_B_WR,
		S_P_RD, S_P_MUL, S_P_WR, S_FIN
	} state_t;

	localparam logic [ssr_pkg::OFF_W-1:0] EDGE_LIM = ssr_pkg::OFF_W'(ssr_pkg::MAX_EDGES);
	localparam logic [ssr_pkg::VCNT_W-1:0] VTX_LIM = ssr_pkg::VCNT_W'(ssr_pkg::MAX_VERTICES);
	localparam logic [ssr_pkg::LVL_W-1:0] STEP_LIM = ssr_pkg::LVL_W'(ssr_pkg::MAX_STEPS);

	// configuration registers
	logic                         method_q;
	logic [15:0]                  decay_q;
	logic [ssr_pkg::LVL_W-1:0]    steps_q;
	logic [ssr_pkg::VCNT_W-1:0]   vcount_q;

	state_t                       st_q;
	logic [2:0]                   kind_q;
	logic [12:0]                  idx_q;
	logic [12:0]                  val_q;
	logic [ssr_pkg::VCNT_W-1:0]   n_q;
	logic [ssr_pkg::LVL_W-1:0]    k_q;
	logic [ssr_pkg::VTX_W-1:0]    q_q;
	logic [ssr_pkg::LVL_W-1:0]    lvl_q;
	logic [ssr_pkg::VCNT_W-1:0]   i_q;
	logic [ssr_pkg::OFF_W-1:0]    x_q;
	logic [ssr_pkg::OFF_W-1:0]    end_q;
	logic [ssr_pkg::OFF_W-1:0]    s_q;
	logic [ssr_pkg::OFF_W-1:0]    dv_q;
	logic [ssr_pkg::VTX_W-1:0]    t_q;
	logic [ssr_pkg::SCORE_W-1:0]  u_q;
	logic [ssr_pkg::SCORE_W-1:0]  acc_q;
	logic [ssr_pkg::SCORE_W-1:0]  pd_q;
	logic                         rb_q;
	logic [ssr_pkg::VTX_W-1:0]    ev_q;
	logic [ssr_pkg::SCORE_W-1:0]  es_q;
	logic [1:0]                   est_q;
	logic                         res_valid_q;
	logic [ssr_pkg::VTX_W-1:0]    vertex_q;
	logic [ssr_pkg::SCORE_W-1:0]  score_q;
	logic [1:0]                   status_q;

	ssr_pkg::gr_req_t             gr_req;
	ssr_pkg::gr_rsp_t             gr_rsp;
	ssr_pkg::vec_req_t            vec_req;
	logic [ssr_pkg::SCORE_W-1:0]  walk_rdata;
	logic [ssr_pkg::SCORE_W-1:0]  back_rdata;
	logic                         clr_busy;

	logic                         div_start;
	logic [ssr_pkg::SCORE_W-1:0]  div_num;
	logic [ssr_pkg::OFF_W-1:0]    div_den;
	logic                         div_busy;
	logic                         div_done;
	logic [ssr_pkg::SCORE_W-1:0]  div_quot;
	logic [ssr_pkg::OFF_W-1:0]    div_rem;

	logic                         cfg_wr;
	logic                         accept;
	logic                         last_i;
	logic [ssr_pkg::OFF_AW-1:0]   i_nx;
	logic [ssr_pkg::OFF_W-1:0]    fwd_d;
	logic [ssr_pkg::OFF_W-1:0]    oo_end;
	logic [ssr_pkg::OFF_W-1:0]    io_d;
	logic [ssr_pkg::SCORE_W+15:0] prod_decay;
	logic [ssr_pkg::SCORE_W+16:0] prod_scale;
	logic [16:0]                  keep;

	// degree from two offsets, zero when not increasing
	function automatic logic [ssr_pkg::OFF_W-1:0] span(input logic [ssr_pkg::OFF_W-1:0] s,
			input logic [ssr_pkg::OFF_W-1:0] e);
		span = (e > s) ? e - s : '0;
	endfunction

	ssr_graph_store u_graph (
		.clk (clk),
		.req (gr_req),
		.rsp (gr_rsp)
	);

	ssr_vec_store u_vec (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (vec_req),
		.walk_rdata (walk_rdata),
		.back_rdata (back_rdata),
		.clr_busy   (clr_busy)
	);

	ssr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// APB configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= 1'b0;
			decay_q  <= ssr_pkg::DECAY_RST;
			steps_q  <= ssr_pkg::STEPS_RST;
			vcount_q <= ssr_pkg::VCOUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ssr_pkg::REG_METHOD: method_q <= pwdata[0];
				ssr_pkg::REG_DECAY:  decay_q  <= pwdata[15:0];
				ssr_pkg::REG_STEPS:  steps_q  <= pwdata[ssr_pkg::LVL_W-1:0];
				ssr_pkg::REG_VCOUNT: vcount_q <= pwdata[ssr_pkg::VCNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ssr_pkg::REG_METHOD: prdata = {31'd0, method_q};
			ssr_pkg::REG_DECAY:  prdata = {16'd0, decay_q};
			ssr_pkg::REG_STEPS:  prdata = {28'd0, steps_q};
			ssr_pkg::REG_VCOUNT: prdata = {21'd0, vcount_q};
		endcase
	end

	// shared helpers
	assign item_ready = (st_q == S_IDLE) && !clr_busy;
	assign accept     = item_valid & item_ready;
	assign last_i     = (i_q == n_q - 1'b1);
	assign i_nx       = i_q + 1'b1;
	assign fwd_d      = span(s_q, gr_rsp.oo_rdata);
	assign oo_end     = (gr_rsp.oo_rdata > EDGE_LIM) ? EDGE_LIM : gr_rsp.oo_rdata;
	assign io_d       = span(s_q, gr_rsp.io_rdata);
	assign keep       = 17'h10000 - {1'b0, decay_q};
	assign prod_decay = back_rdata * decay_q;
	assign prod_scale = back_rdata * keep;

	// memory and divider requests
	always_comb begin
		gr_req    = '0;
		vec_req   = '0;
		div_start = 1'b0;
		div_num   = u_q;
		div_den   = fwd_d;
		gr_req.load_addr = idx_q;
		gr_req.load_data = val_q;
		unique case (st_q)
			S_DISP: begin
				gr_req.oo_we = (kind_q == ssr_pkg::KIND_OUT_OFF) && (idx_q <= 13'(VTX_LIM));
				gr_req.io_we = (kind_q == ssr_pkg::KIND_IN_OFF) && (idx_q <= 13'(VTX_LIM));
				gr_req.on_we = (kind_q == ssr_pkg::KIND_OUT_NBR) && (idx_q < EDGE_LIM);
				gr_req.in_we = (kind_q == ssr_pkg::KIND_IN_NBR) && (idx_q < EDGE_LIM);
				vec_req.back_raddr = {rb_q, idx_q[ssr_pkg::VTX_W-1:0]};
			end
			S_INIT: begin
				vec_req.walk_we    = 1'b1;
				vec_req.walk_waddr = {ssr_pkg::LVL_W'(0), i_q[ssr_pkg::VTX_W-1:0]};
				vec_req.walk_wdata = (i_q[ssr_pkg::VTX_W-1:0] == q_q) ? ssr_pkg::SCORE_ONE : '0;
			end
			S_F_OFF0: gr_req.io_raddr = i_q;
			S_F_OFF1: gr_req.io_raddr = i_nx;
			S_F_E0: begin
				gr_req.in_raddr    = x_q[ssr_pkg::EDGE_AW-1:0];
				vec_req.walk_we    = (x_q >= end_q);
				vec_req.walk_waddr = {lvl_q, i_q[ssr_pkg::VTX_W-1:0]};
				vec_req.walk_wdata = acc_q;
			end
			S_F_E1: begin
				gr_req.oo_raddr    = {1'b0, gr_rsp.in_rdata};
				vec_req.walk_raddr = {lvl_q - 1'b1, gr_rsp.in_rdata};
			end
			S_F_E2: gr_req.oo_raddr = {1'b0, t_q} + 1'b1;
			S_F_E3: div_start = (fwd_d != '0);
			S_B_V0: begin
				vec_req.walk_raddr = {k_q - lvl_q, i_q[ssr_pkg::VTX_W-1:0]};
				gr_req.io_raddr    = i_q;
			end
			S_B_V1: gr_req.io_raddr = i_nx;
			S_B_V2: begin
				div_start = !method_q && (io_d != '0);
				div_den   = io_d;
			end
			S_B_O0: gr_req.oo_raddr = i_q;
			S_B_O1: gr_req.oo_raddr = i_nx;
			S_B_E0: gr_req.on_raddr = x_q[ssr_pkg::EDGE_AW-1:0];
			S_B_E1: vec_req.back_raddr = {~lvl_q[0], gr_rsp.on_rdata};
			S_B_E3: begin
				div_start = 1'b1;
				div_num   = pd_q;
				div_den   = dv_q;
			end
			S_B_WR: begin
				vec_req.back_we    = 1'b1;
				vec_req.back_waddr = {lvl_q[0], i_q[ssr_pkg::VTX_W-1:0]};
				vec_req.back_wdata = acc_q;
			end
			S_P_RD: vec_req.back_raddr = {k_q[0], i_q[ssr_pkg::VTX_W-1:0]};
			S_P_WR: begin
				vec_req.back_we    = 1'b1;
				vec_req.back_waddr = {k_q[0], i_q[ssr_pkg::VTX_W-1:0]};
				vec_req.back_wdata = pd_q;
			end
			S_FIN: begin
				vec_req.back_we    = 1'b1;
				vec_req.back_waddr = {k_q[0], q_q};
				vec_req.back_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			rb_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= kind;
						idx_q  <= index;
						val_q  <= value;
						n_q    <= (vcount_q > VTX_LIM) ? VTX_LIM : vcount_q;
						k_q    <= (steps_q > STEP_LIM) ? STEP_LIM : steps_q;
						st_q   <= S_DISP;
					end
				end
				S_DISP: begin
					ev_q  <= '0;
					es_q  <= '0;
					est_q <= ssr_pkg::ST_RANGE;
					unique case (kind_q)
						ssr_pkg::KIND_OUT_OFF, ssr_pkg::KIND_IN_OFF:
							st_q <= (idx_q > 13'(VTX_LIM)) ? S_EMIT : S_IDLE;
						ssr_pkg::KIND_OUT_NBR, ssr_pkg::KIND_IN_NBR:
							st_q <= (idx_q >= EDGE_LIM) ? S_EMIT : S_IDLE;
						ssr_pkg::KIND_RUN: begin
							if (val_q >= 13'(n_q)) begin
								st_q <= S_EMIT;
							end else begin
								q_q  <= val_q[ssr_pkg::VTX_W-1:0];
								i_q  <= '0;
								st_q <= S_INIT;
							end
						end
						ssr_pkg::KIND_READ:
							st_q <= (idx_q >= 13'(n_q)) ? S_EMIT : S_RD_WAIT;
						default: st_q <= S_IDLE;
					endcase
				end
				S_RD_WAIT: begin
					ev_q  <= idx_q[ssr_pkg::VTX_W-1:0];
					es_q  <= back_rdata;
					est_q <= ssr_pkg::ST_OK;
					st_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						vertex_q    <= ev_q;
						score_q     <= es_q;
						status_q    <= est_q;
						st_q        <= S_IDLE;
					end
				end
				// level zero of the walk
				S_INIT: begin
					if (last_i) begin
						i_q <= '0;
						if (k_q == '0) begin
							lvl_q <= '0;
							st_q  <= S_B_V0;
						end else begin
							lvl_q <= ssr_pkg::LVL_W'(1);
							st_q  <= S_F_OFF0;
						end
					end else begin
						i_q <= i_nx;
					end
				end
				// forward pass over in-edges
				S_F_OFF0: st_q <= S_F_OFF1;
				S_F_OFF1: begin
					x_q  <= gr_rsp.io_rdata;
					st_q <= S_F_OFF2;
				end
				S_F_OFF2: begin
					end_q <= (gr_rsp.io_rdata > EDGE_LIM) ? EDGE_LIM : gr_rsp.io_rdata;
					acc_q <= '0;
					st_q  <= S_F_E0;
				end
				S_F_E0: begin
					if (x_q >= end_q) begin
						if (last_i) begin
							i_q <= '0;
							if (lvl_q == k_q) begin
								lvl_q <= '0;
								st_q  <= S_B_V0;
							end else begin
								lvl_q <= lvl_q + 1'b1;
								st_q  <= S_F_OFF0;
							end
						end else begin
							i_q  <= i_nx;
							st_q <= S_F_OFF0;
						end
					end else begin
						st_q <= S_F_E1;
					end
				end
				S_F_E1: begin
					if ({1'b0, gr_rsp.in_rdata} >= n_q) begin
						x_q  <= x_q + 1'b1;
						st_q <= S_F_E0;
					end else begin
						t_q  <= gr_rsp.in_rdata;
						st_q <= S_F_E2;
					end
				end
				S_F_E2: begin
					s_q  <= gr_rsp.oo_rdata;
					u_q  <= walk_rdata;
					st_q <= S_F_E3;
				end
				S_F_E3: begin
					if (fwd_d == '0) begin
						x_q  <= x_q + 1'b1;
						st_q <= S_F_E0;
					end else begin
						st_q <= S_F_DIV;
					end
				end
				S_F_DIV: begin
					if (div_done) begin
						acc_q <= ssr_pkg::sat_add(acc_q, div_quot);
						x_q   <= x_q + 1'b1;
						st_q  <= S_F_E0;
					end
				end
				// backward pass, one vertex at a time
				S_B_V0: st_q <= S_B_V1;
				S_B_V1: begin
					u_q  <= walk_rdata;
					s_q  <= gr_rsp.io_rdata;
					st_q <= S_B_V2;
				end
				S_B_V2: begin
					if (method_q || io_d == '0) begin
						acc_q <= u_q;
						st_q  <= (lvl_q == '0) ? S_B_WR : S_B_O0;
					end else begin
						st_q <= S_B_DG;
					end
				end
				S_B_DG: begin
					// diagonal weight: u - ceil(u / deg_in)
					if (div_done) begin
						acc_q <= u_q - div_quot - ssr_pkg::SCORE_W'(div_rem != '0);
						st_q  <= (lvl_q == '0) ? S_B_WR : S_B_O0;
					end
				end
				S_B_O0: st_q <= S_B_O1;
				S_B_O1: begin
					x_q  <= gr_rsp.oo_rdata;
					s_q  <= gr_rsp.oo_rdata;
					st_q <= S_B_O2;
				end
				S_B_O2: begin
					dv_q  <= fwd_d;
					end_q <= oo_end;
					st_q  <= (fwd_d == '0) ? S_B_WR : S_B_E0;
				end
				S_B_E0: st_q <= (x_q >= end_q) ? S_B_WR : S_B_E1;
				S_B_E1: begin
					if ({1'b0, gr_rsp.on_rdata} >= n_q) begin
						x_q  <= x_q + 1'b1;
						st_q <= S_B_E0;
					end else begin
						st_q <= S_B_E2;
					end
				end
				S_B_E2: begin
					pd_q <= prod_decay[ssr_pkg::SCORE_W+15:16];
					st_q <= S_B_E3;
				end
				S_B_E3: st_q <= S_B_DIV;
				S_B_DIV: begin
					if (div_done) begin
						acc_q <= ssr_pkg::sat_add(acc_q, div_quot);
						x_q   <= x_q + 1'b1;
						st_q  <= S_B_E0;
					end
				end
				S_B_WR: begin
					if (last_i) begin
						i_q <= '0;
						if (lvl_q == k_q)
							st_q <= method_q ? S_P_RD : S_FIN;
						else begin
							lvl_q <= lvl_q + 1'b1;
							st_q  <= S_B_V0;
						end
					end else begin
						i_q  <= i_nx;
						st_q <= S_B_V0;
					end
				end
				// pruned variant: scale by (1 - decay)
				S_P_RD:  st_q <= S_P_MUL;
				S_P_MUL: begin
					pd_q <= prod_scale[ssr_pkg::SCORE_W+15:16];
					st_q <= S_P_WR;
				end
				S_P_WR: begin
					if (last_i) begin
						st_q <= S_FIN;
					end else begin
						i_q  <= i_nx;
						st_q <= S_P_RD;
					end
				end
				S_FIN: begin
					rb_q  <= k_q[0];
					ev_q  <= q_q;
					es_q  <= '0;
					est_q <= ssr_pkg::ST_DONE;
					st_q  <= S_EMIT;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign vertex    = vertex_q;
	assign score     = score_q;
	assign status    = status_q;

	// checks
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !item_ready)
		else $error("transaction accepted during clearing pass");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !item_ready)
		else $error("transaction accepted while busy");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN) |=> (st_q == S_EMIT) && (est_q == ssr_pkg::ST_DONE))
		else $error("run finished without a result");

endmodule
`default_nettype wire

// ----- dv/single_source_simrank_engine_tb.sv -----
`default_nettype none
module single_source_simrank_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssr_pkg::*;

	localparam int STALL_LIMIT = 300000;

	typedef struct {
		logic [2:0]  kind;
		logic [12:0] index;
		logic [12:0] value;
	} item_t;

	typedef struct {
		logic [9:0]  vertex;
		logic [31:0] score;
		logic [1:0]  status;
	} score_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  kind = '0;
	logic [12:0] index = '0;
	logic [12:0] value = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [9:0]  vertex;
	logic [31:0] score;
	logic [1:0]  status;

	single_source_simrank_engine uut (.*);

	always #1 clk = ~clk;

	// pending transactions and expected results
	item_t  pending_items[$];
	score_t expected_scores[$];
	item_t  cur_item;

	// predictor copy of configuration and graph state
	logic        cfg_method = 1'b0;
	logic [15:0] cfg_decay = DECAY_RST;
	logic [3:0]  cfg_steps = STEPS_RST;
	logic [10:0] cfg_vcount = VCOUNT_RST;
	logic [12:0] g_out_off[0:MAX_VERTICES];
	logic [9:0]  g_out_nbr[0:MAX_EDGES-1];
	logic [12:0] g_in_off[0:MAX_VERTICES];
	logic [9:0]  g_in_nbr[0:MAX_EDGES-1];
	logic [31:0] walk_vec[0:MAX_STEPS][0:MAX_VERTICES-1];
	logic [31:0] back_vec[0:1][0:MAX_VERTICES-1];
	bit          score_bank = 0;

	int  fails = 0;
	int  runs_done = 0;
	int  reads_done = 0;
	int  results_checked = 0;
	bit  no_idle = 0;
	int  hold_token = 0;
	int  hold_seen = 0;
	int  hold_cnt = 0;
	int  quiet_cycles = 0;

	function automatic longint unsigned sat32(longint unsigned x);
		return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
	endfunction

	function automatic longint unsigned degree(bit out_side, int v);
		longint unsigned a, b;
		a = out_side ? g_out_off[v] : g_in_off[v];
		b = out_side ? g_out_off[v+1] : g_in_off[v+1];
		return (b > a) ? b - a : 0;
	endfunction

	function automatic int edge_stop(bit out_side, int v);
		int e;
		e = out_side ? g_out_off[v+1] : g_in_off[v+1];
		return (e > MAX_EDGES) ? MAX_EDGES : e;
	endfunction

	function automatic longint unsigned diag_weight(int v, longint unsigned u);
		longint unsigned d;
		d = degree(0, v);
		if (d == 0)
			return u;
		return (u * (d - 1)) / d;
	endfunction

	// forward walk, backward decay pass, scaling for the pruned variant
	function automatic void simrank_query(int q, int n, int k);
		longint unsigned acc, d;
		int t, e, cur;
		for (int i = 0; i < MAX_VERTICES; i++)
			walk_vec[0][i] = '0;
		walk_vec[0][q] = SCORE_ONE;
		for (int l = 1; l <= k; l++) begin
			for (int i = 0; i < n; i++) begin
				acc = 0;
				e = edge_stop(0, i);
				for (int x = g_in_off[i]; x < e; x++) begin
					t = g_in_nbr[x];
					if (t >= n)
						continue;
					d = degree(1, t);
					if (d == 0)
						continue;
					acc = sat32(acc + walk_vec[l-1][t] / d);
				end
				walk_vec[l][i] = acc[31:0];
			end
		end
		for (int i = 0; i < n; i++)
			back_vec[0][i] = cfg_method ? walk_vec[k][i] : diag_weight(i, walk_vec[k][i]);
		for (int l = 1; l <= k; l++) begin
			cur = l & 1;
			for (int i = 0; i < n; i++) begin
				acc = cfg_method ? walk_vec[k-l][i] : diag_weight(i, walk_vec[k-l][i]);
				d = degree(1, i);
				e = edge_stop(1, i);
				if (d != 0) begin
					for (int x = g_out_off[i]; x < e; x++) begin
						t = g_out_nbr[x];
						if (t >= n)
							continue;
						acc = sat32(acc + (longint'(back_vec[1-cur][t]) * cfg_decay) / (d << 16));
					end
				end
				back_vec[cur][i] = acc[31:0];
			end
		end
		score_bank = k[0];
		if (cfg_method)
			for (int i = 0; i < n; i++)
				back_vec[score_bank][i] =
					(longint'(back_vec[score_bank][i]) * (65536 - cfg_decay)) >> 16;
		back_vec[score_bank][q] = '0;
	endfunction

	// expected result of one accepted transaction
	function automatic void predict_transaction(item_t it);
		score_t r;
		int n, k;
		n = (cfg_vcount > MAX_VERTICES) ? MAX_VERTICES : cfg_vcount;
		k = (cfg_steps > MAX_STEPS) ? MAX_STEPS : cfg_steps;
		r = '{vertex: '0, score: '0, status: ST_RANGE};
		case (it.kind)
			KIND_OUT_OFF, KIND_IN_OFF: begin
				if (it.index > MAX_VERTICES)
					expected_scores.push_back(r);
				else if (it.kind == KIND_OUT_OFF)
					g_out_off[it.index] = it.value;
				else
					g_in_off[it.index] = it.value;
			end
			KIND_OUT_NBR, KIND_IN_NBR: begin
				if (it.index >= MAX_EDGES)
					expected_scores.push_back(r);
				else if (it.kind == KIND_OUT_NBR)
					g_out_nbr[it.index] = it.value[9:0];
				else
					g_in_nbr[it.index] = it.value[9:0];
			end
			KIND_RUN: begin
				if (it.value < n) begin
					simrank_query(it.value, n, k);
					r = '{vertex: it.value[9:0], score: '0, status: ST_DONE};
					runs_done++;
				end
				expected_scores.push_back(r);
			end
			KIND_READ: begin
				if (it.index < n) begin
					r = '{vertex: it.index[9:0], score: back_vec[score_bank][it.index],
						status: ST_OK};
					reads_done++;
				end
				expected_scores.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// reset sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// item driver
	always @(posedge clk) begin
		if (item_valid && item_ready)
			predict_transaction(cur_item);
		if (!item_valid || item_ready) begin
			if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
				cur_item = pending_items.pop_front();
				kind <= cur_item.kind;
				index <= cur_item.index;
				value <= cur_item.value;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		score_t exp_r;
		if (res_valid && res_ready) begin
			results_checked++;
			if (expected_scores.size() == 0) begin
				$error("unexpected result: vertex %0d score %h status %0d", vertex, score, status);
				fails++;
			end else begin
				exp_r = expected_scores.pop_front();
				if (vertex !== exp_r.vertex) begin
					$error("vertex mismatch: expected %0d, got %0d", exp_r.vertex, vertex);
					fails++;
				end
				if (score !== exp_r.score) begin
					$error("score mismatch: expected %h, got %h", exp_r.score, score);
					fails++;
				end
				if (status !== exp_r.status) begin
					$error("status mismatch: expected %0d, got %0d", exp_r.status, status);
					fails++;
				end
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= no_idle || ($urandom_range(99) >= 13);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic add_item(logic [2:0] k, int idx, int val);
		item_t it;
		it.kind = k;
		it.index = idx[12:0];
		it.value = val[12:0];
		pending_items.push_back(it);
	endtask

	task automatic apb_write(logic [1:0] reg_idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (reg_idx)
			REG_METHOD: cfg_method = data[0];
			REG_DECAY:  cfg_decay = data[15:0];
			REG_STEPS:  cfg_steps = data[3:0];
			default:    cfg_vcount = data[10:0];
		endcase
	endtask

	task automatic configure(bit m, int d, int s, int vc);
		apb_write(REG_METHOD, m);
		apb_write(REG_DECAY, d);
		apb_write(REG_STEPS, s);
		apb_write(REG_VCOUNT, vc);
	endtask

	// wait until the engine has gone idle
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() > 0 || item_valid || expected_scores.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random compressed lists for nv vertices, with some inverted offsets
	task automatic load_graph(int nv, int maxdeg);
		int o[0:MAX_VERTICES];
		int top, r;
		for (int side = 0; side < 2; side++) begin
			o[0] = $urandom_range(0, 2);
			top = o[0];
			for (int i = 0; i < nv; i++) begin
				if ($urandom_range(99) < 10 && o[i] > 0)
					o[i+1] = o[i] - $urandom_range(1, o[i]);
				else
					o[i+1] = o[i] + $urandom_range(0, maxdeg);
				if (o[i+1] > top)
					top = o[i+1];
			end
			for (int i = 0; i <= nv; i++)
				add_item(side ? KIND_IN_OFF : KIND_OUT_OFF, i, o[i]);
			for (int x = 0; x < top; x++) begin
				r = $urandom_range(99);
				add_item(side ? KIND_IN_NBR : KIND_OUT_NBR, x,
					(r < 70) ? $urandom_range(0, nv - 1) :
					(r < 85) ? $urandom_range(0, 1023) : $urandom_range(0, 8191));
			end
		end
	endtask

	// malformed and ignored transactions
	task automatic add_noise();
		case ($urandom_range(4))
			0: add_item(KIND_OUT_OFF, $urandom_range(1025, 8191), $urandom_range(0, 8191));
			1: add_item(KIND_IN_NBR, $urandom_range(4096, 8191), $urandom_range(0, 8191));
			2: add_item(3'd6 + $urandom_range(1), $urandom_range(0, 8191),
				$urandom_range(0, 8191));
			3: add_item(KIND_READ, $urandom_range(0, 8191), $urandom_range(0, 8191));
			default: add_item(KIND_RUN, 0, $urandom_range(0, 8191));
		endcase
	endtask

	task automatic run_and_read(int q, int n);
		add_item(KIND_RUN, $urandom_range(0, 8191), q);
		for (int i = 0; i <= n; i++)
			add_item(KIND_READ, i, $urandom_range(0, 8191));
	endtask

	// stimulus
	initial begin
		int n, vc;
		for (int i = 0; i <= MAX_VERTICES; i++) begin
			g_out_off[i] = '0;
			g_in_off[i] = '0;
		end
		for (int i = 0; i < MAX_EDGES; i++) begin
			g_out_nbr[i] = '0;
			g_in_nbr[i] = '0;
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			back_vec[0][i] = '0;
			back_vec[1][i] = '0;
		end
		@(posedge clk);
		wait (arst_n);

		// reset state: reads before any run, range errors, ignored kinds, top-index loads
		add_item(KIND_READ, 0, 0);
		add_item(KIND_READ, 1023, 8191);
		add_item(KIND_READ, 1024, 0);
		add_item(KIND_READ, 8191, 0);
		add_item(KIND_RUN, 0, 8191);
		add_item(KIND_RUN, 8191, 1024);
		add_item(KIND_OUT_OFF, 1025, 5);
		add_item(KIND_IN_OFF, 8191, 8191);
		add_item(KIND_OUT_NBR, 4096, 1);
		add_item(KIND_IN_NBR, 8191, 8191);
		add_item(3'd6, 8191, 8191);
		add_item(3'd7, 0, 0);
		add_item(KIND_OUT_OFF, 1024, 8191);
		add_item(KIND_IN_OFF, 1024, 4096);
		add_item(KIND_OUT_NBR, 4095, 8191);
		add_item(KIND_IN_NBR, 4095, 6144);
		drain();

		// duplicated in-edges grow the walk mass until it saturates
		configure(0, 65535, 8, 2);
		for (int i = 0; i < 3; i++)
			add_item(KIND_OUT_OFF, i, i);
		add_item(KIND_OUT_NBR, 0, 1);
		add_item(KIND_OUT_NBR, 1, 1024);
		for (int i = 0; i < 3; i++)
			add_item(KIND_IN_OFF, i, 4 * i);
		for (int x = 0; x < 8; x++)
			add_item(KIND_IN_NBR, x, x & 1);
		run_and_read(1, 2);
		drain();
		configure(1, 0, 15, 2);
		run_and_read(0, 2);
		drain();

		// offsets past the edge store, inverted offsets, zero steps
		configure(0, 32768, 0, 2);
		add_item(KIND_OUT_OFF, 0, 8000);
		add_item(KIND_OUT_OFF, 1, 8191);
		add_item(KIND_OUT_OFF, 2, 8191);
		add_item(KIND_IN_OFF, 0, 4096);
		add_item(KIND_IN_OFF, 1, 4100);
		add_item(KIND_IN_OFF, 2, 0);
		run_and_read(1, 2);
		drain();
		configure(1, 1, 1, 0);
		add_item(KIND_READ, 0, 0);
		add_item(KIND_RUN, 0, 0);
		drain();

		// random graphs, settings and queries
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 5)
				no_idle = 1;
			case ($urandom_range(3))
				0: vc = $urandom_range(1, 4);
				1: vc = $urandom_range(1, 16);
				2: vc = (phase == 3) ? 2047 : $urandom_range(5, 12);
				default: vc = $urandom_range(8, 16);
			endcase
			configure($urandom_range(1), ($urandom_range(3) == 0) ? 65535 :
				$urandom_range(0, 65535), $urandom_range(0, 15), vc);
			n = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
			if (n <= 16) begin
				load_graph(n, (phase & 1) ? 5 : 3);
				for (int r = 0; r < 2; r++) begin
					run_and_read($urandom_range(0, n - 1), n);
					if ($urandom_range(1))
						add_noise();
				end
			end else begin
				for (int r = 0; r < 12; r++)
					add_item(KIND_READ, $urandom_range(0, 1200), 0);
			end
			for (int r = 0; r < 4; r++)
				add_noise();
			if (phase == 2) begin
				// long receiver stall while reads keep coming
				for (int r = 0; r < 30; r++)
					add_item(KIND_READ, $urandom_range(0, n), $urandom_range(0, 8191));
				hold_token++;
			end
			// sender pauses here until every result is back
			drain();
			no_idle = 0;
		end

		drain();
		$display("covered %0d runs, %0d in-range reads, %0d results checked",
			runs_done, reads_done, results_checked);
		$display("both variants, saturation, bad offsets, range errors and stalls exercised");
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/ssr_pkg.sv
rtl/ssr_div.sv
rtl/ssr_graph_store.sv
rtl/ssr_vec_store.sv
rtl/single_source_simrank_engine.sv
dv/single_source_simrank_engine_tb.sv
